>>> sv/tcls_pkg.sv
`timescale 1ns / 1ps

package tcls_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 56;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ON_COLOR     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME_MS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_COLOR    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_TIME_MS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT = 3'd4;

    // Phase codes
    localparam logic [2:0] PH_START_ON  = 3'd0;
    localparam logic [2:0] PH_WAIT_ON   = 3'd1;
    localparam logic [2:0] PH_START_OFF = 3'd2;
    localparam logic [2:0] PH_WAIT_OFF  = 3'd3;
    localparam logic [2:0] PH_COUNT     = 3'd4;

    // Operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [15:0] FOREVER_COUNT = 16'hFFFF;
    localparam logic [23:0] BLACK         = 24'h000000;
    localparam logic [24:0] NEVER_COLOR   = 25'h1FFFFFF;

    typedef struct packed {
        logic [23:0] on_color;
        logic [15:0] on_time_ms;
        logic [23:0] off_color;
        logic [15:0] off_time_ms;
        logic [15:0] repeat_count;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic [2:0]  step_phase;
        logic [31:0] mark_time;
        logic [15:0] cycles_left;
        logic [24:0] last_sent;
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        running;
        logic [23:0] wire_word;
        logic [23:0] color;
        logic        send_color;
    } result_t;

endpackage

>>> sv/tcls_step_logic.sv
`timescale 1ns / 1ps

module tcls_step_logic
(
    input  tcls_pkg::cfg_t       cfg,
    input  tcls_pkg::seq_state_t state_cur,
    input  logic                 operation,
    input  logic [31:0]          now_ms,
    output tcls_pkg::seq_state_t state_next,
    output tcls_pkg::result_t    result
);

    logic        want_color;
    logic [23:0] req_color;
    logic        send;
    logic [23:0] col;
    logic [31:0] elapsed;
    logic [15:0] cycles_dec;

    assign elapsed    = now_ms - state_cur.mark_time;
    assign cycles_dec = state_cur.cycles_left - 16'd1;

    always_comb
    begin
        state_next = state_cur;
        want_color = 1'b0;
        req_color  = tcls_pkg::BLACK;

        if (operation == tcls_pkg::OP_START)
        begin
            state_next.active      = 1'b1;
            state_next.step_phase  = tcls_pkg::PH_START_ON;
            state_next.cycles_left = cfg.repeat_count;
        end
        else if (state_cur.active)
        begin
            unique case (state_cur.step_phase)
                tcls_pkg::PH_START_ON:
                begin
                    if (cfg.on_time_ms == 16'd0)
                    begin
                        state_next.step_phase = tcls_pkg::PH_START_OFF;
                    end
                    else
                    begin
                        want_color           = 1'b1;
                        req_color            = cfg.on_color;
                        state_next.mark_time = now_ms;
                        state_next.step_phase = tcls_pkg::PH_WAIT_ON;
                    end
                end
                tcls_pkg::PH_WAIT_ON:
                begin
                    if (elapsed >= {16'd0, cfg.on_time_ms})
                    begin
                        state_next.step_phase = tcls_pkg::PH_START_OFF;
                    end
                end
                tcls_pkg::PH_START_OFF:
                begin
                    if (cfg.off_time_ms == 16'd0)
                    begin
                        state_next.step_phase = tcls_pkg::PH_COUNT;
                    end
                    else
                    begin
                        want_color           = 1'b1;
                        req_color            = cfg.off_color;
                        state_next.mark_time = now_ms;
                        state_next.step_phase = tcls_pkg::PH_WAIT_OFF;
                    end
                end
                tcls_pkg::PH_WAIT_OFF:
                begin
                    if (elapsed >= {16'd0, cfg.off_time_ms})
                    begin
                        state_next.step_phase = tcls_pkg::PH_COUNT;
                    end
                end
                tcls_pkg::PH_COUNT:
                begin
                    if (state_cur.cycles_left == tcls_pkg::FOREVER_COUNT)
                    begin
                        state_next.step_phase = tcls_pkg::PH_START_ON;
                    end
                    else
                    begin
                        state_next.cycles_left = cycles_dec;
                        if (cycles_dec == 16'd0)
                        begin
                            state_next.active = 1'b0;
                        end
                        else
                        begin
                            state_next.step_phase = tcls_pkg::PH_START_ON;
                        end
                    end
                end
                default:
                begin
                    // Unreachable phase codes hold the state.
                    state_next = state_cur;
                end
            endcase
        end
        else
        begin
            want_color = 1'b1;
            req_color  = tcls_pkg::BLACK;
        end

        // A color goes out only when it differs from the last one sent.
        send = want_color && (state_cur.last_sent != {1'b0, req_color});
        if (send)
        begin
            state_next.last_sent = {1'b0, req_color};
        end
        col = send ? req_color : 24'd0;

        result.send_color = send;
        result.color      = col;
        result.wire_word  = {col[15:8], col[23:16], col[7:0]};
        result.running    = state_next.active;
        result.phase      = state_next.step_phase;
    end

endmodule

>>> sv/two_color_led_blink_sequencer.sv
`timescale 1ns / 1ps
// A word accepted on s_axis is held in the input register, and its result is then
// registered in the output register for m_axis. Throughput: one word per cycle while
// m_axis does not stall; phase machine and timer compares are combinational in between.
// Reset (rst_n low, asynchronous) clears configuration and sequencer state, sets the
// last sent color to a value that matches no color, and empties both stages.

module two_color_led_blink_sequencer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic                               cfg_wr_en,
    input  logic [tcls_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcls_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tcls_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [31:0] now_ms
    input  logic                               s_axis_tuser,   // [0] operation

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] send_color, [24:1] color, [48:25] wire_word, [49] running,
    // [52:50] phase, [55:53] zero
    output logic [tcls_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    tcls_pkg::cfg_t       cfg_reg;
    tcls_pkg::seq_state_t state_reg;
    tcls_pkg::seq_state_t state_next;
    tcls_pkg::result_t    result;
    tcls_pkg::result_t    out_reg;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    logic        fire;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tcls_pkg::REG_ON_COLOR:     cfg_reg.on_color     <= cfg_data;
                tcls_pkg::REG_ON_TIME_MS:   cfg_reg.on_time_ms   <= cfg_data[15:0];
                tcls_pkg::REG_OFF_COLOR:    cfg_reg.off_color    <= cfg_data;
                tcls_pkg::REG_OFF_TIME_MS:  cfg_reg.off_time_ms  <= cfg_data[15:0];
                tcls_pkg::REG_REPEAT_COUNT: cfg_reg.repeat_count <= cfg_data[15:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg  <= s_axis_tuser;
            in_now_reg <= s_axis_tdata;
        end
    end

    tcls_step_logic u_step
    (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .operation  (in_op_reg),
        .now_ms     (in_now_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active      <= 1'b0;
            state_reg.step_phase  <= tcls_pkg::PH_START_ON;
            state_reg.mark_time   <= 32'd0;
            state_reg.cycles_left <= 16'd0;
            state_reg.last_sent   <= tcls_pkg::NEVER_COLOR;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg};

`ifndef SYNTH
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_op_reg == tcls_pkg::OP_START) |=>
            state_reg.active && (state_reg.step_phase == tcls_pkg::PH_START_ON))
        else $error("start word did not arm the sequencer");

    a_sent_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.send_color |=> state_reg.last_sent == {1'b0, out_reg.color})
        else $error("last sent color does not match the color just sent");

    a_report_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_reg.running == state_reg.active) &&
                 (out_reg.phase == state_reg.step_phase))
        else $error("reported state differs from the sequencer state");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step_phase <= tcls_pkg::PH_COUNT)
        else $error("phase left its legal range");
`endif

endmodule
